// File: hdl/rdlc_pkg.sv
`timescale 1ns / 1ps

package rdlc_pkg;

   localparam int SUM_W     = 63;
   localparam int DELAY_W   = 16;
   localparam int NORM_W    = 16;
   localparam int WEIGHT_W  = 16;
   localparam int COST_W    = 33;
   localparam int MUL_W     = 32;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int SQRT_IN_W = 64;
   localparam int SQRT_RT_W = SQRT_IN_W / 2;
   localparam int CSR_IDX_W = 8;

   localparam logic [SUM_W-1:0]    SUM_MAX   = {SUM_W{1'b1}};
   localparam logic [DELAY_W-1:0]  DELAY_MAX = {DELAY_W{1'b1}};
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'd256;

   localparam logic [CSR_IDX_W-1:0] CSR_PICKUP_WEIGHT   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELIVERY_WEIGHT = 8'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_QUAD,
      ST_ACCUM,
      ST_ROOT1_GO,
      ST_ROOT1_WAIT,
      ST_ROOT2_GO,
      ST_ROOT2_WAIT,
      ST_WEIGHT_P,
      ST_WEIGHT_D,
      ST_COST,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_status_type;

endpackage

// File: hdl/route_delay_l4_cost.sv
`timescale 1ns / 1ps
// stop transaction that is not last: two passes through the shared multiplier plus one
// saturating add (SQUARE, QUAD, ACCUM); the next stop is accepted once ACCUM is done
// last stop: the result is set by four runs of the bit-serial square root unit and two
// weight multiplies; the next stop is accepted once OUT hands the result over
// a result left waiting at the output holds only the next last stop in its output state
// synchronous active-high reset clears both sums, sets both weights to 1.0, empties output
module route_delay_l4_cost #(
   parameter int TIME_BITS = 17,
   localparam int REQ_DATA_W = ((2 * TIME_BITS + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [REQ_DATA_W-1:0]               req_tdata,   // arrival_time, desired_time
   input  logic                                req_tuser,   // is_pickup
   input  logic                                req_tlast,   // last_stop
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [71:0]                         rsp_tdata,   // route_cost, pickup_norm, delivery_norm
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rdlc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rdlc_pkg::WEIGHT_W-1:0]       csr_data
);

   localparam int DIFF_W = (TIME_BITS > rdlc_pkg::DELAY_W) ? TIME_BITS : rdlc_pkg::DELAY_W;
   localparam int SUM_W  = rdlc_pkg::SUM_W;
   localparam int NW     = rdlc_pkg::NORM_W;
   localparam int CW     = rdlc_pkg::COST_W;
   localparam int MW     = rdlc_pkg::MUL_W;

   rdlc_pkg::state_type                  state_ff, state_in;
   logic [rdlc_pkg::DELAY_W-1:0]         delay_ff, delay_in;
   logic                                 pick_ff, pick_in;
   logic                                 last_ff, last_in;
   logic                                 side_ff, side_in;
   logic [SUM_W-1:0]                     psum_ff, psum_in;
   logic [SUM_W-1:0]                     dsum_ff, dsum_in;
   logic [NW-1:0]                        pnorm_ff, pnorm_in;
   logic [NW-1:0]                        dnorm_ff, dnorm_in;
   logic [CW-1:0]                        prod_ff, prod_in;
   logic [CW-1:0]                        cost_ff, cost_in;
   logic [rdlc_pkg::WEIGHT_W-1:0]        pw_ff, pw_in;
   logic [rdlc_pkg::WEIGHT_W-1:0]        dw_ff, dw_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]                        rsp_cost_ff, rsp_cost_in;
   logic [NW-1:0]                        rsp_pn_ff, rsp_pn_in;
   logic [NW-1:0]                        rsp_dn_ff, rsp_dn_in;

   logic [TIME_BITS-1:0]                 arr;
   logic [TIME_BITS-1:0]                 des;
   logic [DIFF_W-1:0]                    diff;
   logic                                 req_take;
   logic                                 slot_free;
   logic [MW-1:0]                        mul_a, mul_b;
   logic [rdlc_pkg::PROD_W-1:0]          mul_p;
   logic                                 sq_start;
   logic [rdlc_pkg::SQRT_IN_W-1:0]       sq_operand;
   rdlc_pkg::sqrt_status_type            sq_status;
   logic [rdlc_pkg::SQRT_RT_W-1:0]       sq_root;
   logic [SUM_W+1:0]                     acc_sum;
   logic [SUM_W-1:0]                     acc_base;
   logic [SUM_W-1:0]                     acc_sat;
   logic [CW:0]                          cost_sum;

   rdlc_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   rdlc_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (sq_operand),
      .status  (sq_status),
      .root    (sq_root)
   );

   assign arr       = req_tdata[TIME_BITS-1:0];
   assign des       = req_tdata[2*TIME_BITS-1:TIME_BITS];
   assign diff      = DIFF_W'(arr) - DIFF_W'(des);
   assign req_tready = (state_ff == rdlc_pkg::ST_IDLE);
   assign req_take  = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;

   assign acc_base = pick_ff ? psum_ff : dsum_ff;
   assign acc_sum  = {2'b00, acc_base} + {1'b0, mul_p};
   assign acc_sat  = (acc_sum > {2'b00, rdlc_pkg::SUM_MAX}) ? rdlc_pkg::SUM_MAX
                                                           : acc_sum[SUM_W-1:0];
   assign cost_sum = {1'b0, prod_ff} + {1'b0, mul_p[CW-1:0]};

   always_comb begin
      state_in     = state_ff;
      delay_in     = delay_ff;
      pick_in      = pick_ff;
      last_in      = last_ff;
      side_in      = side_ff;
      psum_in      = psum_ff;
      dsum_in      = dsum_ff;
      pnorm_in     = pnorm_ff;
      dnorm_in     = dnorm_ff;
      prod_in      = prod_ff;
      cost_in      = cost_ff;
      pw_in        = pw_ff;
      dw_in        = dw_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_cost_in  = rsp_cost_ff;
      rsp_pn_in    = rsp_pn_ff;
      rsp_dn_in    = rsp_dn_ff;
      mul_a        = '0;
      mul_b        = '0;
      sq_start     = 1'b0;
      sq_operand   = '0;

      if (csr_valid) begin
         if (csr_index == rdlc_pkg::CSR_PICKUP_WEIGHT) begin
            pw_in = csr_data;
         end else if (csr_index == rdlc_pkg::CSR_DELIVERY_WEIGHT) begin
            dw_in = csr_data;
         end
      end

      unique case (state_ff)
         rdlc_pkg::ST_IDLE: begin
            if (req_take) begin
               // early arrival counts as zero, large delay clamps
               if (arr <= des) begin
                  delay_in = '0;
               end else if (diff > DIFF_W'(rdlc_pkg::DELAY_MAX)) begin
                  delay_in = rdlc_pkg::DELAY_MAX;
               end else begin
                  delay_in = diff[rdlc_pkg::DELAY_W-1:0];
               end
               pick_in  = req_tuser;
               last_in  = req_tlast;
               side_in  = 1'b0;
               state_in = rdlc_pkg::ST_SQUARE;
            end
         end
         rdlc_pkg::ST_SQUARE: begin
            mul_a    = MW'(delay_ff);
            mul_b    = MW'(delay_ff);
            state_in = rdlc_pkg::ST_QUAD;
         end
         rdlc_pkg::ST_QUAD: begin
            mul_a    = mul_p[MW-1:0];
            mul_b    = mul_p[MW-1:0];
            state_in = rdlc_pkg::ST_ACCUM;
         end
         rdlc_pkg::ST_ACCUM: begin
            if (pick_ff) begin
               psum_in = acc_sat;
            end else begin
               dsum_in = acc_sat;
            end
            state_in = last_ff ? rdlc_pkg::ST_ROOT1_GO : rdlc_pkg::ST_IDLE;
         end
         rdlc_pkg::ST_ROOT1_GO: begin
            sq_start   = 1'b1;
            sq_operand = side_ff ? {1'b0, dsum_ff} : {1'b0, psum_ff};
            state_in   = rdlc_pkg::ST_ROOT1_WAIT;
         end
         rdlc_pkg::ST_ROOT1_WAIT: begin
            if (sq_status.done) begin
               state_in = rdlc_pkg::ST_ROOT2_GO;
            end
         end
         rdlc_pkg::ST_ROOT2_GO: begin
            sq_start   = 1'b1;
            sq_operand = rdlc_pkg::SQRT_IN_W'(sq_root);
            state_in   = rdlc_pkg::ST_ROOT2_WAIT;
         end
         rdlc_pkg::ST_ROOT2_WAIT: begin
            if (sq_status.done) begin
               if (side_ff) begin
                  dnorm_in = sq_root[NW-1:0];
                  state_in = rdlc_pkg::ST_WEIGHT_P;
               end else begin
                  pnorm_in = sq_root[NW-1:0];
                  side_in  = 1'b1;
                  state_in = rdlc_pkg::ST_ROOT1_GO;
               end
            end
         end
         rdlc_pkg::ST_WEIGHT_P: begin
            mul_a    = MW'(pw_ff);
            mul_b    = MW'(pnorm_ff);
            state_in = rdlc_pkg::ST_WEIGHT_D;
         end
         rdlc_pkg::ST_WEIGHT_D: begin
            mul_a    = MW'(dw_ff);
            mul_b    = MW'(dnorm_ff);
            prod_in  = mul_p[CW-1:0];
            state_in = rdlc_pkg::ST_COST;
         end
         rdlc_pkg::ST_COST: begin
            cost_in  = CW'(cost_sum >> 8);
            state_in = rdlc_pkg::ST_OUT;
         end
         rdlc_pkg::ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_cost_in  = cost_ff;
               rsp_pn_in    = pnorm_ff;
               rsp_dn_in    = dnorm_ff;
               psum_in      = '0;
               dsum_in      = '0;
               state_in     = rdlc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rdlc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rdlc_pkg::ST_IDLE;
         psum_ff      <= '0;
         dsum_ff      <= '0;
         pw_ff        <= rdlc_pkg::WEIGHT_ONE;
         dw_ff        <= rdlc_pkg::WEIGHT_ONE;
         rsp_valid_ff <= 1'b0;
         side_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         psum_ff      <= psum_in;
         dsum_ff      <= dsum_in;
         pw_ff        <= pw_in;
         dw_ff        <= dw_in;
         rsp_valid_ff <= rsp_valid_in;
         side_ff      <= side_in;
      end
      delay_ff    <= delay_in;
      pick_ff     <= pick_in;
      last_ff     <= last_in;
      pnorm_ff    <= pnorm_in;
      dnorm_ff    <= dnorm_in;
      prod_ff     <= prod_in;
      cost_ff     <= cost_in;
      rsp_cost_ff <= rsp_cost_in;
      rsp_pn_ff   <= rsp_pn_in;
      rsp_dn_ff   <= rsp_dn_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_dn_ff, rsp_pn_ff, rsp_cost_ff};

   // a new result only comes out of the output state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == rdlc_pkg::ST_OUT))
      else $error("result raised outside output state");

   // both sums are cleared once the result is handed over
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == rdlc_pkg::ST_OUT && slot_free) |=> (psum_ff == '0 && dsum_ff == '0))
      else $error("sums not cleared after result");

   // root unit is idle whenever a stop transaction is accepted
   assert property (@(posedge clock) disable iff (reset)
      req_take |-> !sq_status.busy)
      else $error("stop accepted while root unit busy");

endmodule

// File: hdl/rdlc_mul.sv
`timescale 1ns / 1ps

module rdlc_mul (
   input  logic                              clock,
   input  logic [rdlc_pkg::MUL_W-1:0]        op_a,
   input  logic [rdlc_pkg::MUL_W-1:0]        op_b,
   output logic [rdlc_pkg::PROD_W-1:0]       product
);

   logic [rdlc_pkg::PROD_W-1:0] product_ff;
   logic [rdlc_pkg::PROD_W-1:0] product_in;

   assign product_in = rdlc_pkg::PROD_W'(op_a) * rdlc_pkg::PROD_W'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// File: hdl/rdlc_isqrt.sv
`timescale 1ns / 1ps

module rdlc_isqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [rdlc_pkg::SQRT_IN_W-1:0]     operand,
   output rdlc_pkg::sqrt_status_type          status,
   output logic [rdlc_pkg::SQRT_RT_W-1:0]     root
);

   localparam int RT_W  = rdlc_pkg::SQRT_RT_W;
   localparam int REM_W = RT_W + 2;
   localparam int SH_W  = RT_W + 4;
   localparam int CNT_W = $clog2(RT_W);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic [rdlc_pkg::SQRT_IN_W-1:0]   x_ff, x_in;
   logic [REM_W-1:0]                 rem_ff, rem_in;
   logic [RT_W-1:0]                  root_ff, root_in;
   logic [SH_W-1:0]                  rem_sh;
   logic [SH_W-1:0]                  trial;
   logic                             fits;

   // one result bit per cycle, two operand bits consumed per step
   assign rem_sh = {rem_ff, x_ff[rdlc_pkg::SQRT_IN_W-1 -: 2]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign fits   = (rem_sh >= trial);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(RT_W - 1);
         x_in    = operand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         x_in    = x_ff << 2;
         rem_in  = fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
         root_in = {root_ff[RT_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign root        = root_ff;

endmodule
